@@ design/hsl2rgb_pkg.sv @@
// shared constants, types and elaboration-time tables for the hsl to rgb converter
package hsl2rgb_pkg;

   // fixed-point format of all fractions
   localparam int FRAC_BITS = 16;
   localparam int FX_W      = FRAC_BITS + 1;

   // field widths
   localparam int HUE_W  = 16;
   localparam int PCT_W  = 8;
   localparam int PCTI_W = 7;
   localparam int CH_W   = 8;
   localparam int HMOD_W = 9;

   localparam int HUE_RANGE = 360;
   localparam int PCT_MAX   = 100;
   localparam int HALF_PCT  = 50;
   localparam int CH_MAX    = 255;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   typedef logic [FX_W-1:0] fx_type;
   typedef logic [FX_W:0]   level_type;

   localparam fx_type FX_ONE        = {1'b1, {FRAC_BITS{1'b0}}};
   localparam fx_type FX_THIRD      = FX_W'((64'd1 << FRAC_BITS) / 64'd3);
   localparam fx_type FX_TWO_THIRDS = FX_W'((64'd2 << FRAC_BITS) / 64'd3);

   // coarse reciprocal of 360 for hue mod 360, quotient estimate is exact or one low
   localparam int HQ_SHIFT = 24;
   localparam int HQ_W     = 8;
   localparam int HQ_RCP_W = 16;
   localparam logic [HQ_RCP_W-1:0] HQ_RCP = HQ_RCP_W'((64'd1 << HQ_SHIFT) / 64'd360);

   // fine reciprocal of 360 for the hue fraction, estimate is exact or one low
   localparam int HF_N_W   = HMOD_W + FRAC_BITS;
   localparam int HF_SHIFT = HF_N_W;
   localparam int HF_RCP_W = FRAC_BITS + 1;
   localparam logic [HF_RCP_W-1:0] HF_RCP = HF_RCP_W'((64'd1 << HF_SHIFT) / 64'd360);

   typedef fx_type pct_fx_table_type [0:PCT_MAX];
   typedef logic [CH_W-1:0] grey_table_type [0:PCT_MAX];

   function automatic pct_fx_table_type build_pct_fx();
      pct_fx_table_type t;
      for (int i = 0; i <= PCT_MAX; i++) begin
         t[i] = FX_W'((64'(i) << FRAC_BITS) / PCT_MAX);
      end
      return t;
   endfunction

   function automatic grey_table_type build_grey();
      grey_table_type t;
      for (int i = 0; i <= PCT_MAX; i++) begin
         t[i] = CH_W'((i * CH_MAX) / PCT_MAX);
      end
      return t;
   endfunction

   localparam pct_fx_table_type PCT_FX   = build_pct_fx();
   localparam grey_table_type   GREY_LVL = build_grey();

endpackage

@@ design/hsl_to_rgb_converter_top.sv @@
// hsl to rgb converter: seven-stage pipeline, one colour per beat
//
//   channel   dir   tdata fields (low bit up)                  notes
//   req_*     in    hue_deg[15:0] sat_pct[23:16] light[31:24]  one colour per beat
//   rsp_*     out   red[7:0] green[15:8] blue[23:16]           one result per beat
//
// one beat per clock sustained while rsp_tready stays high; rsp_tvalid rises once the beat reaches stage 7
// each stage holds its own valid bit and advances when the stage after it is empty
// or moving, so bubbles close up under a stalled output
// req_tready drops only when every stage holds a beat and rsp_tready is low
// reset clears the valid bits; the datapath registers are not reset
module hsl_to_rgb_converter_top
   import hsl2rgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // hue_deg, saturation_pct, lightness_pct
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // red, green, blue
);

   localparam int STAGES = 7;
   localparam int LAST   = STAGES - 1;

   logic [STAGES-1:0] vld_ff, vld_in, take;

   // stage 1
   logic [HUE_W-1:0]  hue_s1_ff, hue_s1_in;
   logic [HQ_W-1:0]   hq_s1_ff, hq_s1_in;
   fx_type            s_s1_ff, s_s1_in, l_s1_ff, l_s1_in;
   logic              lt_s1_ff, lt_s1_in, grey_s1_ff, grey_s1_in;
   logic [CH_W-1:0]   gval_s1_ff, gval_s1_in;
   // stage 2
   logic [HMOD_W-1:0]   hmod_s2_ff, hmod_s2_in;
   logic [2*FX_W:0]     t1p_s2_ff, t1p_s2_in;
   fx_type              s_s2_ff, l_s2_ff;
   logic                lt_s2_ff, grey_s2_ff;
   logic [CH_W-1:0]     gval_s2_ff;
   // stage 3
   logic [HMOD_W-1:0] hmod_s3_ff;
   fx_type            hfq_s3_ff, hfq_s3_in, t1_s3_ff, t1_s3_in, l_s3_ff;
   logic              grey_s3_ff;
   logic [CH_W-1:0]   gval_s3_ff;
   // stage 4
   fx_type            h_s4_ff, h_s4_in, lo_s4_ff, lo_s4_in, d_s4_ff, d_s4_in;
   logic              grey_s4_ff;
   logic [CH_W-1:0]   gval_s4_ff;
   // stage 5
   fx_type            m_s5_ff [0:2];
   fx_type            m_s5_in [0:2];
   fx_type            lo_s5_ff, d_s5_ff;
   logic              grey_s5_ff;
   logic [CH_W-1:0]   gval_s5_ff;
   // stage 6
   level_type         v_s6_ff [0:2];
   level_type         v_s6_in [0:2];
   logic              grey_s6_ff;
   logic [CH_W-1:0]   gval_s6_ff;
   // stage 7
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // handshake and valid chain
   always_comb begin
      take[LAST] = !vld_ff[LAST] || rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         take[i] = !vld_ff[i] || take[i+1];
      end
      vld_in[0] = take[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = take[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = take[0];
   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = rsp_data_ff;

   // stage 1: clamp, percent tables, coarse hue quotient
   logic [PCTI_W-1:0]         sat_cl, lit_cl;
   logic [HUE_W+HQ_RCP_W-1:0] hq_prod;

   always_comb begin
      sat_cl = (req_tdata[HUE_W +: PCT_W] > PCT_W'(PCT_MAX)) ? PCTI_W'(PCT_MAX)
                                                             : req_tdata[HUE_W +: PCTI_W];
      lit_cl = (req_tdata[HUE_W+PCT_W +: PCT_W] > PCT_W'(PCT_MAX)) ? PCTI_W'(PCT_MAX)
                                                                   : req_tdata[HUE_W+PCT_W +: PCTI_W];
      hue_s1_in  = req_tdata[HUE_W-1:0];
      hq_prod    = (HUE_W+HQ_RCP_W)'(hue_s1_in) * (HUE_W+HQ_RCP_W)'(HQ_RCP);
      hq_s1_in   = hq_prod[HQ_SHIFT +: HQ_W];
      s_s1_in    = PCT_FX[sat_cl];
      l_s1_in    = PCT_FX[lit_cl];
      lt_s1_in   = lit_cl < PCTI_W'(HALF_PCT);
      grey_s1_in = sat_cl == '0;
      gval_s1_in = GREY_LVL[lit_cl];
   end

   // stage 2: hue mod 360, product for the upper level
   logic [HUE_W:0] hq_x360, hrem;
   logic [FX_W:0]  t1_b;

   always_comb begin
      hq_x360    = (HUE_W+1)'(hq_s1_ff) * (HUE_W+1)'(HUE_RANGE);
      hrem       = (HUE_W+1)'(hue_s1_ff) - hq_x360;
      hmod_s2_in = (hrem >= (HUE_W+1)'(HUE_RANGE)) ? HMOD_W'(hrem - (HUE_W+1)'(HUE_RANGE))
                                                    : HMOD_W'(hrem);
      t1_b       = lt_s1_ff ? ((FX_W+1)'(FX_ONE) + (FX_W+1)'(s_s1_ff)) : (FX_W+1)'(s_s1_ff);
      t1p_s2_in  = (2*FX_W+1)'(l_s1_ff) * (2*FX_W+1)'(t1_b);
   end

   // stage 3: hue fraction estimate, upper level
   logic [HF_N_W-1:0]          hf_n3;
   logic [HF_N_W+HF_RCP_W-1:0] hf_prod;
   logic [FX_W+1:0]            t1p_hi, t1_full;

   always_comb begin
      hf_n3     = {hmod_s2_ff, {FRAC_BITS{1'b0}}};
      hf_prod   = (HF_N_W+HF_RCP_W)'(hf_n3) * (HF_N_W+HF_RCP_W)'(HF_RCP);
      hfq_s3_in = hf_prod[HF_SHIFT +: FX_W];
      t1p_hi    = (FX_W+2)'(t1p_s2_ff[FRAC_BITS +: FX_W+1]);
      t1_full   = lt_s2_ff ? t1p_hi
                           : ((FX_W+2)'(l_s2_ff) + (FX_W+2)'(s_s2_ff) - t1p_hi);
      t1_s3_in  = t1_full[FX_W-1:0];
   end

   // stage 4: hue fraction correction, lower level and spread
   logic [HF_N_W:0] hf_n4, hfq_x360, hf_rem;
   logic [FX_W:0]   two_l, t2_diff;

   always_comb begin
      hf_n4    = (HF_N_W+1)'({hmod_s3_ff, {FRAC_BITS{1'b0}}});
      hfq_x360 = (HF_N_W+1)'(hfq_s3_ff) * (HF_N_W+1)'(HUE_RANGE);
      hf_rem   = hf_n4 - hfq_x360;
      h_s4_in  = (hf_rem >= (HF_N_W+1)'(HUE_RANGE)) ? hfq_s3_ff + FX_W'(1) : hfq_s3_ff;
      two_l    = {l_s3_ff, 1'b0};
      t2_diff  = two_l - (FX_W+1)'(t1_s3_ff);
      lo_s4_in = (two_l < (FX_W+1)'(t1_s3_ff)) ? '0 : t2_diff[FX_W-1:0];
      d_s4_in  = (t1_s3_ff >= lo_s4_in) ? t1_s3_ff - lo_s4_in : '0;
   end

   // ramp weight: 6c on the rising edge, one on the plateau, 6(2/3-c) falling, else zero
   function automatic fx_type ramp_weight(input fx_type c);
      logic [FX_W+2:0] six_c, six_rem;
      logic [FX_W:0]   two_c;
      logic [FX_W+1:0] three_c;
      fx_type          rem;
      six_c   = (FX_W+3)'({c, 2'b00}) + (FX_W+3)'({c, 1'b0});
      two_c   = {c, 1'b0};
      three_c = (FX_W+2)'({c, 1'b0}) + (FX_W+2)'(c);
      rem     = (c <= FX_TWO_THIRDS) ? FX_TWO_THIRDS - c : '0;
      six_rem = (FX_W+3)'({rem, 2'b00}) + (FX_W+3)'({rem, 1'b0});
      if (six_c < (FX_W+3)'(FX_ONE)) begin
         return six_c[FX_W-1:0];
      end else if (two_c < (FX_W+1)'(FX_ONE)) begin
         return FX_ONE;
      end else if (three_c < (FX_W+2)'({FX_ONE, 1'b0})) begin
         return six_rem[FX_W-1:0];
      end else begin
         return '0;
      end
   endfunction

   // stage 5: channel positions wrapped into one turn, ramp weights
   logic [FX_W:0] c0_sum;
   fx_type        c0, c2;

   always_comb begin
      c0_sum = (FX_W+1)'(h_s4_ff) + (FX_W+1)'(FX_THIRD);
      c0     = (c0_sum > (FX_W+1)'(FX_ONE)) ? FX_W'(c0_sum - (FX_W+1)'(FX_ONE))
                                             : FX_W'(c0_sum);
      c2     = (h_s4_ff >= FX_THIRD) ? h_s4_ff - FX_THIRD : h_s4_ff + (FX_ONE - FX_THIRD);
      m_s5_in[0] = ramp_weight(c0);
      m_s5_in[1] = ramp_weight(h_s4_ff);
      m_s5_in[2] = ramp_weight(c2);
   end

   // stage 6: channel level = lo + d * weight
   logic [2*FX_W-1:0] wprod [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wprod[k]   = (2*FX_W)'(d_s5_ff) * (2*FX_W)'(m_s5_ff[k]);
         v_s6_in[k] = (FX_W+1)'(lo_s5_ff) + wprod[k][FRAC_BITS +: FX_W+1];
      end
   end

   // stage 7: scale by 255, saturate, grey bypass
   logic [FX_W+8:0] scaled [0:2];
   logic [CH_W+1:0] chan_hi [0:2];
   logic [CH_W-1:0] chan [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         scaled[k]  = (FX_W+9)'({v_s6_ff[k], 8'b0}) - (FX_W+9)'(v_s6_ff[k]);
         chan_hi[k] = scaled[k][FRAC_BITS +: CH_W+2];
         chan[k]    = (chan_hi[k] > (CH_W+2)'(CH_MAX)) ? CH_W'(CH_MAX) : chan_hi[k][CH_W-1:0];
      end
      rsp_data_in = grey_s6_ff ? {gval_s6_ff, gval_s6_ff, gval_s6_ff}
                               : {chan[2], chan[1], chan[0]};
   end

   // datapath registers, each stage loads when it advances
   always_ff @(posedge clock) begin
      if (take[0]) begin
         hue_s1_ff  <= hue_s1_in;
         hq_s1_ff   <= hq_s1_in;
         s_s1_ff    <= s_s1_in;
         l_s1_ff    <= l_s1_in;
         lt_s1_ff   <= lt_s1_in;
         grey_s1_ff <= grey_s1_in;
         gval_s1_ff <= gval_s1_in;
      end
      if (take[1]) begin
         hmod_s2_ff <= hmod_s2_in;
         t1p_s2_ff  <= t1p_s2_in;
         s_s2_ff    <= s_s1_ff;
         l_s2_ff    <= l_s1_ff;
         lt_s2_ff   <= lt_s1_ff;
         grey_s2_ff <= grey_s1_ff;
         gval_s2_ff <= gval_s1_ff;
      end
      if (take[2]) begin
         hmod_s3_ff <= hmod_s2_ff;
         hfq_s3_ff  <= hfq_s3_in;
         t1_s3_ff   <= t1_s3_in;
         l_s3_ff    <= l_s2_ff;
         grey_s3_ff <= grey_s2_ff;
         gval_s3_ff <= gval_s2_ff;
      end
      if (take[3]) begin
         h_s4_ff    <= h_s4_in;
         lo_s4_ff   <= lo_s4_in;
         d_s4_ff    <= d_s4_in;
         grey_s4_ff <= grey_s3_ff;
         gval_s4_ff <= gval_s3_ff;
      end
      if (take[4]) begin
         m_s5_ff    <= m_s5_in;
         lo_s5_ff   <= lo_s4_ff;
         d_s5_ff    <= d_s4_ff;
         grey_s5_ff <= grey_s4_ff;
         gval_s5_ff <= gval_s4_ff;
      end
      if (take[5]) begin
         v_s6_ff    <= v_s6_in;
         grey_s6_ff <= grey_s5_ff;
         gval_s6_ff <= gval_s5_ff;
      end
      if (take[6]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // an empty output stage means the whole chain can move
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage empty");

   // a held middle stage keeps its beat
   a_mid_stage_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && !take[3] |=> vld_ff[3] && $stable(h_s4_ff) && $stable(d_s4_ff))
      else $error("stalled stage lost or changed its beat");

   // the two levels never leave the unit range
   a_levels_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> ((FX_W+1)'(lo_s4_ff) + (FX_W+1)'(d_s4_ff)) <= (FX_W+1)'(FX_ONE))
      else $error("upper level above one");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> vld_ff == '0)
      else $error("pipeline not empty after reset");
`endif

endmodule

@@ sim/hsl_to_rgb_converter_top_tb.sv @@
// testbench for the hsl to rgb converter: random and directed colours checked against a predictor
`timescale 1ns / 100ps

module hsl_to_rgb_converter_top_tb;
   import hsl2rgb_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int ITEMS_PER_RUN  = 482;
   localparam int DRAIN_CYCLES   = 30;
   localparam int HOLD_START     = 100;
   localparam int HOLD_CYCLES    = 120;
   localparam int MAX_REPORTS    = 10;

   typedef enum int {
      PH_DIRECTED,
      PH_FREE_RUN,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_IDLE
   } run_phase_type;

   // packed in tdata order, top member lands in the high bits
   typedef struct packed {
      logic [PCT_W-1:0] light;
      logic [PCT_W-1:0] sat;
      logic [HUE_W-1:0] hue;
   } hsl_beat_type;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } rgb_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   hsl_beat_type  pending_colors [$];
   rgb_beat_type  expected_rgb [$];
   run_phase_type run_phase = PH_DIRECTED;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            rsp_hold_left = 0;
   int            free_run_cycles = 0;
   int            cycle_count = 0;
   int            fail_count = 0;

   hsl_to_rgb_converter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // hue_deg, saturation_pct, lightness_pct
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // red, green, blue
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one channel: sample the piecewise-linear ramp at position pos
   function automatic logic [CH_W-1:0] ramp_channel(longint pos, longint hi, longint lo);
      longint one;
      longint span;
      longint level;
      longint rem;
      longint scaled;
      one  = longint'(1) << FRAC_BITS;
      span = (hi > lo) ? hi - lo : 0;
      if (pos < 0) begin
         pos = pos + one;
      end else if (pos > one) begin
         pos = pos - one;
      end
      if (6 * pos < one) begin
         level = lo + ((span * 6 * pos) >> FRAC_BITS);
      end else if (2 * pos < one) begin
         level = hi;
      end else if (3 * pos < 2 * one) begin
         rem = (2 * one) / 3 - pos;
         if (rem < 0) begin
            rem = 0;
         end
         level = lo + ((span * 6 * rem) >> FRAC_BITS);
      end else begin
         level = lo;
      end
      if (level < 0) begin
         level = 0;
      end
      scaled = (level * CH_MAX) >> FRAC_BITS;
      if (scaled > CH_MAX) begin
         scaled = CH_MAX;
      end
      return CH_W'(scaled);
   endfunction

   function automatic rgb_beat_type hsl_to_rgb(hsl_beat_type c);
      longint       one;
      longint       hue;
      longint       sat;
      longint       lit;
      longint       h;
      longint       s;
      longint       l;
      longint       t1;
      longint       t2;
      longint       third;
      rgb_beat_type r;
      one = longint'(1) << FRAC_BITS;
      hue = longint'(c.hue) % HUE_RANGE;
      sat = (c.sat > PCT_MAX) ? PCT_MAX : longint'(c.sat);
      lit = (c.light > PCT_MAX) ? PCT_MAX : longint'(c.light);
      if (sat == 0) begin
         r.red   = CH_W'((lit * CH_MAX) / PCT_MAX);
         r.green = r.red;
         r.blue  = r.red;
         return r;
      end
      h = (hue * one) / HUE_RANGE;
      s = (sat * one) / PCT_MAX;
      l = (lit * one) / PCT_MAX;
      if (lit < HALF_PCT) begin
         t1 = (l * (one + s)) >> FRAC_BITS;
      end else begin
         t1 = l + s - ((l * s) >> FRAC_BITS);
      end
      t2 = 2 * l - t1;
      if (t2 < 0) begin
         t2 = 0;
      end
      third   = one / 3;
      r.red   = ramp_channel(h + third, t1, t2);
      r.green = ramp_channel(h, t1, t2);
      r.blue  = ramp_channel(h - third, t1, t2);
      return r;
   endfunction

   function automatic logic [PCT_W-1:0] random_pct();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         return '0;
      end else if (pick < 18) begin
         return PCT_W'($urandom_range(255, 101));
      end else if (pick < 25) begin
         return PCT_W'($urandom);
      end else if (pick < 30) begin
         return (pick < 28) ? PCT_W'(PCT_MAX) : PCT_W'(HALF_PCT);
      end
      return PCT_W'($urandom_range(PCT_MAX, 1));
   endfunction

   function automatic hsl_beat_type random_color();
      hsl_beat_type c;
      c.hue   = ($urandom_range(99) < 25) ? HUE_W'($urandom) : HUE_W'($urandom_range(719));
      c.sat   = random_pct();
      c.light = random_pct();
      return c;
   endfunction

   task automatic queue_color(int hue, int sat, int light);
      hsl_beat_type c;
      c.hue   = HUE_W'(hue);
      c.sat   = PCT_W'(sat);
      c.light = PCT_W'(light);
      pending_colors.push_back(c);
   endtask

   task automatic drain_pipeline();
      while (pending_colors.size() != 0 || expected_rgb.size() != 0 || req_tvalid) begin
         @(negedge clock);
      end
   endtask

   // driver: prediction is taken at the accepting edge, then the next beat is offered
   always @(posedge clock) begin : drive_req
      hsl_beat_type next_color;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rgb.push_back(hsl_to_rgb(hsl_beat_type'(req_tdata)));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_colors.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_color = pending_colors.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_color;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long output hold-off while the sender keeps pushing, so the pipe fills
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold_left   <= 0;
         free_run_cycles <= 0;
      end else begin
         if (run_phase == PH_FREE_RUN) begin
            free_run_cycles <= free_run_cycles + 1;
         end
         if (run_phase == PH_FREE_RUN && free_run_cycles == HOLD_START) begin
            rsp_hold_left <= HOLD_CYCLES;
         end else if (rsp_hold_left > 0) begin
            rsp_hold_left <= rsp_hold_left - 1;
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      rgb_beat_type got;
      rgb_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rgb_beat_type'(rsp_tdata);
            if (expected_rgb.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("unexpected beat: rgb %02h %02h %02h", got.red, got.green, got.blue);
               end
            end else begin
               want = expected_rgb.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("mismatch: expected rgb %02h %02h %02h, got %02h %02h %02h",
                              want.red, want.green, want.blue, got.red, got.green, got.blue);
                  end
               end
            end
         end
         rsp_tready <= (rsp_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // hue wrap, primaries and secondaries, grey, clamped percentages
      queue_color(0, 100, 50);
      queue_color(120, 100, 50);
      queue_color(240, 100, 50);
      queue_color(60, 100, 50);
      queue_color(180, 100, 50);
      queue_color(300, 100, 50);
      queue_color(359, 100, 50);
      queue_color(360, 100, 50);
      queue_color(65535, 100, 50);
      queue_color(65535, 255, 255);
      queue_color(0, 0, 0);
      queue_color(200, 0, 100);
      queue_color(77, 0, 33);
      queue_color(10, 0, 255);
      queue_color(90, 255, 49);
      queue_color(90, 101, 50);
      queue_color(210, 1, 1);
      queue_color(330, 50, 100);
      queue_color(45, 100, 0);
      queue_color(270, 60, 49);
      queue_color(150, 35, 51);
      queue_color(32768, 128, 170);
      drain_pipeline();

      for (int p = PH_FREE_RUN; p <= PH_BOTH_IDLE; p++) begin
         run_phase = run_phase_type'(p);
         case (run_phase)
            PH_SEND_IDLE: begin
               send_idle_pct  = 55;
               recv_stall_pct = 0;
            end
            PH_RECV_STALL: begin
               send_idle_pct  = 0;
               recv_stall_pct = 55;
            end
            PH_BOTH_IDLE: begin
               send_idle_pct  = 15;
               recv_stall_pct = 15;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int i = 0; i < ITEMS_PER_RUN; i++) begin
            pending_colors.push_back(random_color());
         end
         // sender waits here until every result of the run is back
         drain_pipeline();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_rgb.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/hsl2rgb_pkg.sv
design/hsl_to_rgb_converter_top.sv
sim/hsl_to_rgb_converter_top_tb.sv
